// File: rtl/dvtf_pkg.sv
// Shared types and constants for the decal vertex time fade block.
// No dependencies; every other file imports this package.
package dvtf_pkg;

	localparam int TIME_W  = 24;	// stay and fade registers, fade offset
	localparam int ELAP_W  = 33;	// exact difference of two signed 32-bit times
	localparam int DEPTH_W = 17;	// Q0.16 depth fade plus the bit for one
	localparam int Q_W     = 17;	// fade fraction, 0..65536
	localparam int CH_W    = 8;
	localparam int NCH     = 4;
	localparam int RGBA_W  = CH_W * NCH;
	localparam int MIX_W   = 24;	// blended channel, at most 255 * 2^16
	localparam int CFG_IDX_W = 8;

	localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(65536);

	// register indices on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_STAY  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FADE  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_START = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_END   = CFG_IDX_W'(3);

	localparam logic [TIME_W-1:0] STAY_RST  = TIME_W'(0);
	localparam logic [TIME_W-1:0] FADE_RST  = TIME_W'(1000);
	localparam logic [RGBA_W-1:0] START_RST = 32'hFFFF_FFFF;
	localparam logic [RGBA_W-1:0] END_RST   = 32'h0000_0000;

	typedef struct packed {
		logic [TIME_W-1:0] stay;
		logic [TIME_W-1:0] fade;
		logic [RGBA_W-1:0] start_rgba;
		logic [RGBA_W-1:0] end_rgba;
	} cfg_t;

	// one vertex that lies inside the fade window
	typedef struct packed {
		logic [TIME_W-1:0]  d;	// elapsed - stay, 1..fade
		logic [DEPTH_W-1:0] depth;
	} fade_item_t;

endpackage

// File: rtl/dvtf_front.sv
// Front end: accepts vertex beats, takes the exact elapsed time and keeps only
// those inside the fade window. Depends on dvtf_pkg.
module dvtf_front import dvtf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [31:0]       now_time,
	input  logic signed [31:0]       tri_start_time,
	input  logic [DEPTH_W-1:0]       depth_fade,
	input  logic                     q_full,
	output logic                     q_push,
	output fade_item_t               q_item
);

	logic                     valid_s1;
	logic signed [ELAP_W-1:0] elapsed_s1;
	logic [DEPTH_W-1:0]       depth_s1;
	logic signed [ELAP_W:0]   diff;
	logic                     hit;
	logic                     leave;

	// offset into the window; positive and not beyond fade means a hit
	assign diff = {elapsed_s1[ELAP_W-1], elapsed_s1}
		- $signed({(ELAP_W + 1 - TIME_W)'(0), cfg.stay});
	assign hit  = !diff[ELAP_W] && (diff != '0)
		&& (diff <= $signed({(ELAP_W + 1 - TIME_W)'(0), cfg.fade}));

	// drop misses at once; hold a hit until the queue has room
	assign leave    = valid_s1 && (!hit || !q_full);
	assign in_ready = !valid_s1 || leave;
	assign q_push   = valid_s1 && hit && !q_full;
	assign q_item.d     = diff[TIME_W-1:0];
	assign q_item.depth = depth_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			elapsed_s1 <= {now_time[31], now_time} - {tri_start_time[31], tri_start_time};
			depth_s1   <= depth_fade;
		end
	end

`ifndef ASSERT_OFF
	a_push_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_item.d != '0) && (q_item.d <= cfg.fade))
		else $error("front pushed an offset outside the fade window");
`endif

endmodule

// File: rtl/dvtf_fifo.sv
// Short queue between front end and back end, register based.
// Depends on dvtf_pkg for the item type.
module dvtf_fifo import dvtf_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  fade_item_t push_item,
	output logic       full,
	input  logic       pop,
	output fade_item_t pop_item,
	output logic       empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	fade_item_t       mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a beat");
`endif

endmodule

// File: rtl/dvtf_div.sv
// Pipelined restoring divider for the fade fraction f = d * 2^16 / fade,
// one quotient bit per stage. Depends on dvtf_pkg.
module dvtf_div import dvtf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic [TIME_W-1:0]  fade,
	input  logic               in_valid,
	input  fade_item_t         in_item,
	output logic               out_valid,
	output logic [Q_W-1:0]     out_f,
	output logic [DEPTH_W-1:0] out_depth
);

	localparam int NSTAGE = Q_W;

	logic               vld_s [NSTAGE];
	logic [TIME_W-1:0]  rem_s [NSTAGE];
	logic [Q_W-1:0]     quo_s [NSTAGE];
	logic [DEPTH_W-1:0] dep_s [NSTAGE];

	for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
		logic [TIME_W:0]    trial;
		logic [Q_W-1:0]     quo_in;
		logic [DEPTH_W-1:0] dep_in;
		logic               vld_in;
		logic               ge;

		// d never exceeds fade, so the first stage needs no shift
		if (i == 0) begin : g_first
			assign trial  = {1'b0, in_item.d};
			assign quo_in = '0;
			assign dep_in = in_item.depth;
			assign vld_in = in_valid;
		end else begin : g_next
			assign trial  = {rem_s[i-1], 1'b0};
			assign quo_in = quo_s[i-1];
			assign dep_in = dep_s[i-1];
			assign vld_in = vld_s[i-1];
		end

		assign ge = (trial >= {1'b0, fade});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i] <= ge ? TIME_W'(trial - {1'b0, fade}) : trial[TIME_W-1:0];
				quo_s[i] <= {quo_in[Q_W-2:0], ge};
				dep_s[i] <= dep_in;
			end
		end
	end

	assign out_valid = vld_s[NSTAGE-1];
	assign out_f     = quo_s[NSTAGE-1];
	assign out_depth = dep_s[NSTAGE-1];

`ifndef ASSERT_OFF
	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_f <= ONE_Q16)
		else $error("fade fraction above one");
`endif

endmodule

// File: rtl/dvtf_mix.sv
// Back end colour stages: blend start and end colours by the fade fraction,
// scale by depth fade, saturate, and hold the result beat. Depends on dvtf_pkg.
module dvtf_mix import dvtf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	input  logic [Q_W-1:0]     in_f,
	input  logic [DEPTH_W-1:0] in_depth,
	output logic               adv,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CH_W-1:0]    red,
	output logic [CH_W-1:0]    green,
	output logic [CH_W-1:0]    blue,
	output logic [CH_W-1:0]    alpha
);

	localparam int PROD_W = MIX_W + DEPTH_W;

	logic               valid_s1;
	logic [MIX_W-1:0]   mix_s1 [NCH];
	logic [DEPTH_W-1:0] depth_s1;
	logic [MIX_W-1:0]   mix_d  [NCH];
	logic [CH_W-1:0]    chan_d [NCH];
	logic [CH_W-1:0]    chan_s2 [NCH];
	logic               valid_s2;

	assign adv = !valid_s2 || out_ready;

	always_comb begin
		logic [CH_W-1:0]    s;
		logic [CH_W-1:0]    e;
		logic [Q_W-1:0]     inv;
		logic [MIX_W+1:0]   sum;
		logic [PROD_W-1:0]  prod;
		logic [CH_W:0]      hi;
		for (int k = 0; k < NCH; k++) begin
			s   = cfg.start_rgba[CH_W*k +: CH_W];
			e   = cfg.end_rgba[CH_W*k +: CH_W];
			inv = ONE_Q16 - in_f;
			sum = (MIX_W + 2)'(s) * (MIX_W + 2)'(inv)
				+ (MIX_W + 2)'(e) * (MIX_W + 2)'(in_f);
			mix_d[k] = sum[MIX_W-1:0];
			// depth above one can push the top bit; saturate then
			prod = PROD_W'(mix_s1[k]) * PROD_W'(depth_s1);
			hi   = prod[PROD_W-1 -: CH_W + 1];
			chan_d[k] = hi[CH_W] ? {CH_W{1'b1}} : hi[CH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			depth_s1 <= in_depth;
			for (int k = 0; k < NCH; k++) begin
				mix_s1[k]  <= mix_d[k];
				chan_s2[k] <= chan_d[k];
			end
		end
	end

	assign out_valid = valid_s2;
	assign red   = chan_s2[0];
	assign green = chan_s2[1];
	assign blue  = chan_s2[2];
	assign alpha = chan_s2[3];

endmodule

// File: rtl/decal_vertex_time_fade.sv
// Decal vertex time fade: each vertex beat carries the current time, the
// creation time of its triangle and a Q0.16 depth fade. Vertices whose elapsed
// time lies after the stay period and within the fade period give one colour
// beat (red, green, blue, alpha); all others are dropped and give no beat.
// Channels: in_valid/in_ready and out_valid/out_ready, each beat taken when
// valid and ready are both high. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_data); write only while no vertex is in flight.
// Throughput: one vertex per cycle while the queue has room and the receiver
// takes every beat. Path: a vertex passes the front register, the queue, the
// 17 quotient stages of the fade divider and the two colour stages before its
// colour beat shows on out_valid.
// Reset: asynchronous, active low on arst_n; registers return to stay 0,
// fade 1000, start colour all ones, end colour zero; the pipeline empties.
// Receiver stall: the whole back end holds, the queue fills, and in_ready
// falls once it and the front register are full; no beat is lost.
module decal_vertex_time_fade import dvtf_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [RGBA_W-1:0]     cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [31:0]    now_time,
	input  logic signed [31:0]    tri_start_time,
	input  logic [DEPTH_W-1:0]    depth_fade,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CH_W-1:0]       red,
	output logic [CH_W-1:0]       green,
	output logic [CH_W-1:0]       blue,
	output logic [CH_W-1:0]       alpha
);

	cfg_t               cfg_q;
	logic               q_push;
	logic               q_full;
	logic               q_empty;
	logic               q_pop;
	fade_item_t         q_in;
	fade_item_t         q_out;
	logic               adv;
	logic               div_valid;
	logic [Q_W-1:0]     div_f;
	logic [DEPTH_W-1:0] div_depth;

	// Configuration registers; ignore writes to unknown indices.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stay       <= STAY_RST;
			cfg_q.fade       <= FADE_RST;
			cfg_q.start_rgba <= START_RST;
			cfg_q.end_rgba   <= END_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STAY:  cfg_q.stay       <= cfg_data[TIME_W-1:0];
				REG_FADE:  cfg_q.fade       <= cfg_data[TIME_W-1:0];
				REG_START: cfg_q.start_rgba <= cfg_data;
				REG_END:   cfg_q.end_rgba   <= cfg_data;
				default:   ;
			endcase
		end
	end

	// Front end: classify and push window hits.
	dvtf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.now_time       (now_time),
		.tri_start_time (tri_start_time),
		.depth_fade     (depth_fade),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_item         (q_in)
	);

	dvtf_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (q_out),
		.empty     (q_empty)
	);

	// Back end advances as one; pop only when it moves.
	assign q_pop = adv && !q_empty;

	dvtf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.fade      (cfg_q.fade),
		.in_valid  (!q_empty),
		.in_item   (q_out),
		.out_valid (div_valid),
		.out_f     (div_f),
		.out_depth (div_depth)
	);

	dvtf_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (div_valid),
		.in_f      (div_f),
		.in_depth  (div_depth),
		.adv       (adv),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.alpha     (alpha)
	);

endmodule
